>>> src/bgc_pkg.sv
// ----------------------------------------------------------------------------
// bgc_pkg
// Shared types and constants for the button gesture classifier.
// ----------------------------------------------------------------------------
package bgc_pkg;

  // Long-press levels the block can use (1 to 4)
  localparam int unsigned LEVELS = 4;

  // Threshold registers always present in the register map
  localparam int unsigned NumThr  = 4;
  localparam int unsigned ThrIdxW = 2;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned WinW    = 16;
  localparam int unsigned CntW    = 3;
  localparam int unsigned HeW     = 7;
  localparam int unsigned EvW     = 3;
  localparam int unsigned TallyW  = 2;
  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned CfgDatW = 16;

  localparam logic [CntW-1:0]   LevelsCnt = CntW'(LEVELS);
  localparam logic [TallyW-1:0] TallyMax  = 2'd3;
  localparam logic [TallyW-1:0] TallyTwo  = 2'd2;

  // Event codes
  localparam logic [EvW-1:0] EvNone     = 3'd0;
  localparam logic [EvW-1:0] EvLongBase = 3'd1;
  localparam logic [EvW-1:0] EvRelease  = 3'd5;
  localparam logic [EvW-1:0] EvDouble   = 3'd6;
  localparam logic [EvW-1:0] EvSingle   = 3'd7;

  // Handler enable bit positions beyond the long levels
  localparam logic [2:0] HeRelease = 3'd4;
  localparam logic [2:0] HeDouble  = 3'd5;
  localparam logic [2:0] HeSingle  = 3'd6;

  // Reset values of the configuration registers
  localparam logic [WinW-1:0] DebounceRst = 16'd30;
  localparam logic [WinW-1:0] DclickRst   = 16'd400;

  // Register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgDebounce = 4'd0,
    CfgDclick   = 4'd1,
    CfgLvlCnt   = 4'd2,
    CfgThr0     = 4'd3,
    CfgThr1     = 4'd4,
    CfgThr2     = 4'd5,
    CfgThr3     = 4'd6,
    CfgHandler  = 4'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [WinW-1:0]              debounce;
    logic [WinW-1:0]              dclick;
    logic [CntW-1:0]              lvl_cnt;
    logic [NumThr-1:0][WinW-1:0]  thr;
    logic [HeW-1:0]               handler_en;
  } cfg_t;

  typedef struct packed {
    logic [EvW-1:0] ev;
    logic           keep;
  } res_t;

endpackage

>>> src/bgc_cfg_regs.sv
// ----------------------------------------------------------------------------
// bgc_cfg_regs
// Configuration register file: decodes writes and holds the settings.
// ----------------------------------------------------------------------------
module bgc_cfg_regs
  import bgc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_en_i,
  input  logic [CfgIdxW-1:0] wr_idx_i,
  input  logic [CfgDatW-1:0] wr_data_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Write decode; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_idx_i)
        CfgDebounce: cfg_d.debounce   = wr_data_i;
        CfgDclick:   cfg_d.dclick     = wr_data_i;
        CfgLvlCnt:   cfg_d.lvl_cnt    = wr_data_i[CntW-1:0];
        CfgThr0:     cfg_d.thr[0]     = wr_data_i;
        CfgThr1:     cfg_d.thr[1]     = wr_data_i;
        CfgThr2:     cfg_d.thr[2]     = wr_data_i;
        CfgThr3:     cfg_d.thr[3]     = wr_data_i;
        CfgHandler:  cfg_d.handler_en = wr_data_i[HeW-1:0];
        default:     cfg_d            = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce   <= DebounceRst;
      cfg_q.dclick     <= DclickRst;
      cfg_q.lvl_cnt    <= '0;
      cfg_q.thr        <= '0;
      cfg_q.handler_en <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> src/bgc_core.sv
// ----------------------------------------------------------------------------
// bgc_core
// Gesture state and the single-pass classification of one sample.
// ----------------------------------------------------------------------------
module bgc_core
  import bgc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic             pin_i,
  input  logic [TimeW-1:0] now_i,
  input  cfg_t             cfg_i,
  output res_t             res_o
);

  logic [TallyW-1:0] tally_q, tally_d;
  logic [TimeW-1:0]  press_q, press_d;
  logic [TimeW-1:0]  prior_q, prior_d;
  logic              await_q, await_d;
  logic              long_q, long_d;

  logic [CntW-1:0]    n_use;
  logic [ThrIdxW-1:0] top;
  logic [TimeW-1:0]   held;
  logic [TimeW-1:0]   gap;
  logic [NumThr-1:0]  hit;
  logic               found;
  logic [ThrIdxW-1:0] lvl;
  res_t               res;

  // Levels in use, clamped to the build limit
  assign n_use = (cfg_i.lvl_cnt > LevelsCnt) ? LevelsCnt : cfg_i.lvl_cnt;
  assign top   = ThrIdxW'(n_use - CntW'(1));
  assign held  = now_i - press_q;
  assign gap   = now_i - prior_q;

  // Highest threshold met on release
  always_comb begin
    found = 1'b0;
    lvl   = '0;
    for (int k = 0; k < NumThr; k++) begin
      hit[k] = (CntW'(k) < n_use) && (held >= {16'd0, cfg_i.thr[k]});
    end
    for (int k = 0; k < NumThr; k++) begin
      if (hit[k]) begin
        found = 1'b1;
        lvl   = ThrIdxW'(k);
      end
    end
  end

  // Classification and next state
  always_comb begin
    tally_d  = tally_q;
    press_d  = press_q;
    prior_d  = prior_q;
    await_d  = await_q;
    long_d   = long_q;
    res.ev   = EvNone;
    res.keep = 1'b1;
    if (pin_i) begin
      if (!await_q) begin
        press_d = now_i;
        if (tally_q != TallyMax) tally_d = tally_q + TallyW'(1);
        await_d = 1'b1;
        long_d  = 1'b0;
      end else if (!long_q && (n_use != '0)) begin
        // long press fires while still held
        if ((held >= {16'd0, cfg_i.thr[top]}) && cfg_i.handler_en[3'(top)]) begin
          long_d   = 1'b1;
          tally_d  = '0;
          await_d  = 1'b0;
          res.ev   = EvLongBase + EvW'(top);
          res.keep = 1'b0;
        end
      end
    end else if (tally_q == '0) begin
      // release with no counted press
      if (long_q) begin
        long_d = 1'b0;
        if (cfg_i.handler_en[HeRelease]) res.ev = EvRelease;
      end
      res.keep = 1'b0;
    end else if (held < {16'd0, cfg_i.debounce}) begin
      res.keep = 1'b0;
    end else if (await_q) begin
      await_d = 1'b0;
      prior_d = now_i;
      if (long_q) begin
        long_d   = 1'b0;
        res.keep = 1'b0;
      end else if (found) begin
        if (cfg_i.handler_en[3'(lvl)]) begin
          tally_d  = '0;
          res.ev   = EvLongBase + EvW'(lvl);
          res.keep = 1'b0;
        end
      end else if (tally_q == TallyTwo) begin
        tally_d = '0;
        if (cfg_i.handler_en[HeDouble]) res.ev = EvDouble;
      end
    end else if (gap > {16'd0, cfg_i.dclick}) begin
      // double-click window ran out
      tally_d = '0;
      if (cfg_i.handler_en[HeSingle]) res.ev = EvSingle;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tally_q <= '0;
      press_q <= '0;
      prior_q <= '0;
      await_q <= 1'b0;
      long_q  <= 1'b0;
    end else if (step_i) begin
      tally_q <= tally_d;
      press_q <= press_d;
      prior_q <= prior_d;
      await_q <= await_d;
      long_q  <= long_d;
    end
  end

  assign res_o = res;

`ifndef SYNTH
  // a held press always has a counted press behind it
  a_await_tally: assert property (@(posedge clk_i) disable iff (!rst_ni)
    await_q |-> (tally_q != '0))
    else $error("press held with zero tally");

  // state only moves on a step
  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> ($stable(tally_q) && $stable(await_q) && $stable(long_q)))
    else $error("state changed without an item");

  // long press on hold leaves the fired flag set and the press closed
  a_long_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && pin_i && (res.ev != EvNone)) |=> (long_q && !await_q && (tally_q == '0)))
    else $error("long press on hold left wrong state");

  // release event only comes from an empty tally
  a_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && (res.ev == EvRelease)) |-> (!pin_i && (tally_q == '0) && long_q))
    else $error("release event from a counted press");

  // double click clears the tally
  a_double: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && (res.ev == EvDouble)) |=> (tally_q == '0))
    else $error("double click kept the tally");
`endif

endmodule

>>> src/button_gesture_classifier.sv
// ----------------------------------------------------------------------------
// button_gesture_classifier
// Sorts sampled push-button levels into click, double-click and long-press
// events, one result item per input item.
// ----------------------------------------------------------------------------
// Datapath: the input register feeds one classification pass into the result
//   register. Throughput: one item per cycle while the output is not stalled;
//   the gesture state updates in one pass.
// Reset: asynchronous, active low; clears gesture state and both pipeline
//   valid flags, and loads the configuration defaults.
module button_gesture_classifier
  import bgc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgDatW-1:0] cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               pin_pressed_i,
  input  logic [TimeW-1:0]   now_ms_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [EvW-1:0]     event_code_o,
  output logic               keep_polling_o
);

  cfg_t             cfg;
  res_t             res;
  logic             in_valid_q;
  logic             pin_q;
  logic [TimeW-1:0] now_q;
  logic             out_valid_q;
  res_t             out_q;
  logic             advance;
  logic             step;

  assign cfg_ready_o = 1'b1;

  bgc_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i),
    .wr_idx_i  (cfg_index_i),
    .wr_data_i (cfg_data_i),
    .cfg_o     (cfg)
  );

  // Pipeline flow control
  assign advance    = !out_valid_q || out_ready_i;
  assign step       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      pin_q <= pin_pressed_i;
      now_q <= now_ms_i;
    end
  end

  bgc_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .pin_i  (pin_q),
    .now_i  (now_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign event_code_o   = out_q.ev;
  assign keep_polling_o = out_q.keep;

endmodule
